### rtl/nearest_palette_color_search_defines.svh
// Assertion macros shared by the nearest palette color search RTL.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`ifndef SYNTH
// Plain property check, disabled while in reset.
`define NPCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Implication check: when ante holds, cons must hold in the same cycle.
`define NPCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define NPCS_ASSERT(lbl, clk, rstn, prop)
`define NPCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/npcs_pkg.sv
// Package with shared constants and types of the nearest palette color search.
package npcs_pkg;

  localparam int DEF_PALETTE_ENTRIES = 256;
  localparam int DEF_CHANNEL_BITS    = 8;
  localparam int IN_INDEX_BITS       = 8;
  localparam int OUT_INDEX_BITS      = 8;
  localparam int IN_CHAN_BITS        = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Palette write beat broadcast to every cell.
  typedef struct packed {
    logic                     en;
    logic [IN_INDEX_BITS-1:0] idx;
  } pal_wr_t;

endpackage

### rtl/npcs_cell.sv
// One palette cell: holds an entry and updates the passing query's best match.
module npcs_cell #(
  parameter int CHAN_BITS = 8,
  parameter int IDX_BITS  = 8,
  parameter int CELL_IDX  = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  npcs_pkg::pal_wr_t      wr_i,
  input  logic [CHAN_BITS-1:0]   wr_red_i,
  input  logic [CHAN_BITS-1:0]   wr_green_i,
  input  logic [CHAN_BITS-1:0]   wr_blue_i,
  input  logic                   q_vld_i,
  input  logic [CHAN_BITS-1:0]   q_red_i,
  input  logic [CHAN_BITS-1:0]   q_green_i,
  input  logic [CHAN_BITS-1:0]   q_blue_i,
  input  logic [IDX_BITS-1:0]    q_best_idx_i,
  input  logic [2*CHAN_BITS+1:0] q_best_dist_i,
  output logic                   q_vld_o,
  output logic [CHAN_BITS-1:0]   q_red_o,
  output logic [CHAN_BITS-1:0]   q_green_o,
  output logic [CHAN_BITS-1:0]   q_blue_o,
  output logic [IDX_BITS-1:0]    q_best_idx_o,
  output logic [2*CHAN_BITS+1:0] q_best_dist_o
);
  import npcs_pkg::*;

  localparam int DW = 2 * CHAN_BITS + 2;

  logic [CHAN_BITS-1:0] ent_red_q, ent_green_q, ent_blue_q;
  logic                 vld_q;
  logic [CHAN_BITS-1:0] red_q, green_q, blue_q;
  logic [IDX_BITS-1:0]  best_idx_q, best_idx_d;
  logic [DW-1:0]        best_dist_q, best_dist_d;
  logic [CHAN_BITS-1:0] dr, dg, db;
  logic [2*CHAN_BITS-1:0] sr, sg, sb;
  logic [DW-1:0]        cur_dist;
  logic                 wr_hit;

  // The write beat lands here only when its index names this cell.
  assign wr_hit = wr_i.en && (32'(wr_i.idx) == 32'(CELL_IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_red_q   <= '0;
      ent_green_q <= '0;
      ent_blue_q  <= '0;
    end else if (wr_hit) begin
      ent_red_q   <= wr_red_i;
      ent_green_q <= wr_green_i;
      ent_blue_q  <= wr_blue_i;
    end
  end

  // Squared distance between the passing query and the stored entry.
  always_comb begin
    dr = (q_red_i >= ent_red_q) ? q_red_i - ent_red_q : ent_red_q - q_red_i;
    dg = (q_green_i >= ent_green_q) ? q_green_i - ent_green_q : ent_green_q - q_green_i;
    db = (q_blue_i >= ent_blue_q) ? q_blue_i - ent_blue_q : ent_blue_q - q_blue_i;
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    cur_dist = DW'(sr) + DW'(sg) + DW'(sb);
  end

  // Strictly smaller wins, so ties keep the lower index.
  always_comb begin
    if (cur_dist < q_best_dist_i) begin
      best_idx_d  = IDX_BITS'(CELL_IDX);
      best_dist_d = cur_dist;
    end else begin
      best_idx_d  = q_best_idx_i;
      best_dist_d = q_best_dist_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= q_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q       <= q_red_i;
    green_q     <= q_green_i;
    blue_q      <= q_blue_i;
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
  end

  assign q_vld_o       = vld_q;
  assign q_red_o       = red_q;
  assign q_green_o     = green_q;
  assign q_blue_o      = blue_q;
  assign q_best_idx_o  = best_idx_q;
  assign q_best_dist_o = best_dist_q;

endmodule

### rtl/nearest_palette_color_search.sv
// Top level of the nearest palette color search: a row of palette cells.
// Each palette entry lives in a cell of its own. A write beat is stored by the
// cell it names; writes to indexes beyond the palette are dropped. A query beat
// enters the first cell and moves one cell per cycle, each cell comparing its
// entry against the best match so far, and the next beat is taken only once the
// query has left the row. One query is in the row at a time; the input stalls
// while it runs, and a new query also waits while an earlier result is still
// untaken.
// Reset clears every entry to black at once, with no clearing pass.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = npcs_pkg::DEF_PALETTE_ENTRIES,
  parameter int CHANNEL_BITS    = npcs_pkg::DEF_CHANNEL_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [npcs_pkg::IN_INDEX_BITS-1:0]  entry_index_i,
  input  logic [npcs_pkg::IN_CHAN_BITS-1:0]   red_i,
  input  logic [npcs_pkg::IN_CHAN_BITS-1:0]   green_i,
  input  logic [npcs_pkg::IN_CHAN_BITS-1:0]   blue_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [npcs_pkg::OUT_INDEX_BITS-1:0] best_index_o
);
  import npcs_pkg::*;
  `include "nearest_palette_color_search_defines.svh"

  localparam int N  = PALETTE_ENTRIES;
  localparam int CB = CHANNEL_BITS;
  localparam int IW = $clog2(PALETTE_ENTRIES);
  localparam int DW = 2 * CB + 2;

  logic               busy_q, busy_d;
  logic               out_vld_q, out_vld_d;
  logic [OUT_INDEX_BITS-1:0] out_idx_q;
  logic               in_acc;
  pal_wr_t            wr;
  logic [CB+IN_CHAN_BITS-1:0] red_ext, green_ext, blue_ext;
  logic [CB-1:0]      red_c, green_c, blue_c;
  logic [IW+OUT_INDEX_BITS-1:0] idx_ext;

  logic [N:0]         c_vld;
  logic [CB-1:0]      c_red   [N+1];
  logic [CB-1:0]      c_green [N+1];
  logic [CB-1:0]      c_blue  [N+1];
  logic [IW-1:0]      c_idx   [N+1];
  logic [DW-1:0]      c_dist  [N+1];

  // Input handshake: every beat waits for the row, and queries also for the result register.
  assign in_stall_o = busy_q || (out_vld_q && (command_i == CMD_QUERY));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Channels keep their low CHANNEL_BITS bits.
  assign red_ext   = {{CB{1'b0}}, red_i};
  assign green_ext = {{CB{1'b0}}, green_i};
  assign blue_ext  = {{CB{1'b0}}, blue_i};
  assign red_c     = red_ext[CB-1:0];
  assign green_c   = green_ext[CB-1:0];
  assign blue_c    = blue_ext[CB-1:0];

  assign wr.en  = in_acc && (command_i == CMD_WRITE);
  assign wr.idx = entry_index_i;

  // Head of the row: a fresh query with a distance above any real one.
  assign c_vld[0]   = in_acc && (command_i == CMD_QUERY);
  assign c_red[0]   = red_c;
  assign c_green[0] = green_c;
  assign c_blue[0]  = blue_c;
  assign c_idx[0]   = '0;
  assign c_dist[0]  = '1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    npcs_cell #(
      .CHAN_BITS (CB),
      .IDX_BITS  (IW),
      .CELL_IDX  (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .wr_i          (wr),
      .wr_red_i      (red_c),
      .wr_green_i    (green_c),
      .wr_blue_i     (blue_c),
      .q_vld_i       (c_vld[i]),
      .q_red_i       (c_red[i]),
      .q_green_i     (c_green[i]),
      .q_blue_i      (c_blue[i]),
      .q_best_idx_i  (c_idx[i]),
      .q_best_dist_i (c_dist[i]),
      .q_vld_o       (c_vld[i+1]),
      .q_red_o       (c_red[i+1]),
      .q_green_o     (c_green[i+1]),
      .q_blue_o      (c_blue[i+1]),
      .q_best_idx_o  (c_idx[i+1]),
      .q_best_dist_o (c_dist[i+1])
    );
  end

  // Busy from query entry until the query leaves the last cell.
  always_comb begin
    busy_d = busy_q;
    if (c_vld[0]) begin
      busy_d = 1'b1;
    end else if (c_vld[N]) begin
      busy_d = 1'b0;
    end
  end

  // Result register; it is free whenever a query leaves the row.
  always_comb begin
    out_vld_d = out_vld_q;
    if (c_vld[N]) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign idx_ext = {{OUT_INDEX_BITS{1'b0}}, c_idx[N]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_vld[N]) begin
      out_idx_q <= idx_ext[OUT_INDEX_BITS-1:0];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign best_index_o = out_idx_q;

  // At most one query travels the row.
  `NPCS_ASSERT(a_one_query, clk_i, rst_ni, $onehot0(c_vld))
  // A query in the row means the block is busy.
  `NPCS_ASSERT_IMP(a_busy_row, clk_i, rst_ni, c_vld[N:1] != '0, busy_q)
  // A query leaving the row never meets a waiting result.
  `NPCS_ASSERT_IMP(a_out_free, clk_i, rst_ni, c_vld[N], !out_vld_q)
  // A result appears only after a query left the last cell.
  `NPCS_ASSERT_IMP(a_out_src, clk_i, rst_ni, $rose(out_vld_q), $past(c_vld[N]))

endmodule
